>>> rtl/core/assert_macros.svh
// shared assertion macros, sampled on the rising clock edge, off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("assertion failed");

`endif

>>> rtl/core/bsdb_pkg.sv
package bsdb_pkg;

   localparam int MAX_ORDER_DEF  = 8;
   localparam int MAX_POINTS_DEF = 64;
   localparam int KNOT_DEPTH_DEF = 72;

   localparam int Q_W     = 32;
   localparam int IX_W    = 8;
   localparam int DIV_N_W = 49;
   localparam int DIV_D_W = 33;

   localparam logic [1:0] KIND_KNOT  = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_EVAL  = 2'd2;

   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_LAST  = 1'b1;

   localparam logic [3:0] ORDER_RST = 4'd4;
   localparam logic [5:0] LAST_RST  = 6'd3;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DOMAIN  = 2'd1,
      ST_ZERO_IV = 2'd2
   } status_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/bsdb_ram.sv
module bsdb_ram
   #(parameter int WIDTH = 32,
     parameter int DEPTH = 64)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bsdb_div.sv
module bsdb_div
   import bsdb_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    input  div_req_type req,
    output div_rsp_type rsp);

   // restoring divider, one quotient bit per cycle
   logic               busy_ff;
   logic               done_ff;
   logic [5:0]         cnt_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] dvs_ff;
   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W:0]   trial;
   logic               take;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvs_ff  <= req.divisor;
            quo_ff  <= req.dividend;
         end else if (busy_ff) begin
            rem_ff <= take ? DIV_D_W'(trial - {1'b0, dvs_ff}) : trial[DIV_D_W-1:0];
            quo_ff <= {quo_ff[DIV_N_W-2:0], take};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> rtl/core/bspline_curve_de_boor_eval.sv
// channel  direction  signals                        purpose
// req      in         req_tvalid/tready/tdata/tuser  load knot, load point, evaluate
// rsp      out        rsp_tvalid/tready/tdata/tuser  curve point, span and status
// csr      in         csr_valid/ready/index/data     curve order, last point index
//
// a load is written into its memory on acceptance; the run time of an evaluate
// is set by the shared serial divider and the single multiplier used once per
// coordinate in each blend step
// reset is synchronous; the knot and point memories are not cleared
// req is held off while an evaluate runs, also while its final hand-over waits on a
// full output register; once handed over, new requests are taken while the result waits
module bspline_curve_de_boor_eval
   import bsdb_pkg::*;
   #(parameter int MAX_ORDER  = MAX_ORDER_DEF,
     parameter int MAX_POINTS = MAX_POINTS_DEF,
     parameter int KNOT_DEPTH = KNOT_DEPTH_DEF)
   (input  logic         clock,
    input  logic         reset,
    input  logic         req_tvalid,
    output logic         req_tready,
    // slot_index, knot_value, coord_x, coord_y, coord_z, coord_w, param_t, zero pad
    input  logic [199:0] req_tdata,
    // kind
    input  logic [1:0]   req_tuser,
    output logic         rsp_tvalid,
    input  logic         rsp_tready,
    // point_x, point_y, point_z, point_w, span_found, zero pad
    output logic [135:0] rsp_tdata,
    // status
    output logic [1:0]   rsp_tuser,
    input  logic         csr_valid,
    output logic         csr_ready,
    input  logic         csr_index,
    input  logic [7:0]   csr_data);

   localparam int KA_W = $clog2(KNOT_DEPTH);
   localparam int PT_W = $clog2(MAX_POINTS);
   localparam int RW_W = $clog2(MAX_ORDER);

   typedef enum logic [4:0] {
      S_IDLE, S_LO, S_HI, S_SCAN, S_CP0, S_CP1, S_BK0, S_BK1, S_BK2, S_DIV,
      S_RA, S_RB, S_MUL, S_ACC, S_WB, S_FIN, S_FIN2, S_EMIT
   } state_type;

   state_type  state_ff;
   logic [3:0] order_ff;
   logic [5:0] last_ff;
   logic [IX_W-1:0] k_ff, n_ff, l_ff, i_ff, r_ff, j_ff;
   logic [1:0] c_ff;
   logic signed [31:0] t_ff, ui_ff, f_ff;
   logic       fneg_ff;
   logic [127:0] rowa_ff, rowb_ff;
   logic signed [64:0] prod_ff;
   status_type st_ff;
   logic       kz_ff;
   logic       rsp_valid_ff;
   logic [127:0] rsp_pt_ff;
   logic [6:0] rsp_span_ff;
   status_type rsp_st_ff;

   // input fields
   logic [6:0]         in_slot;
   logic signed [31:0] in_knot, in_t;
   logic [127:0]       in_point;
   assign in_slot  = req_tdata[6:0];
   assign in_knot  = req_tdata[38:7];
   assign in_point = req_tdata[166:39];
   assign in_t     = req_tdata[198:167];

   logic accept;
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // clamped order and last index
   logic [IX_W-1:0] k_cl, n_cl, base, bi_idx;
   always_comb begin
      if (order_ff == 4'd0) begin
         k_cl = IX_W'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         k_cl = IX_W'(MAX_ORDER);
      end else begin
         k_cl = IX_W'(order_ff);
      end
      if (int'(last_ff) > MAX_POINTS - 1) begin
         n_cl = IX_W'(MAX_POINTS - 1);
      end else begin
         n_cl = IX_W'(last_ff);
      end
   end
   assign base   = l_ff - k_ff + IX_W'(1);
   assign bi_idx = j_ff + base + r_ff;

   // knot memory, reads past the store give zero
   logic [IX_W-1:0]    kn_idx;
   logic [31:0]        knot_rd;
   logic signed [31:0] knot_q;
   always_comb begin
      unique case (state_ff)
         S_IDLE:  kn_idx = k_cl - IX_W'(1);
         S_LO:    kn_idx = n_ff + IX_W'(1);
         S_HI:    kn_idx = k_ff - IX_W'(1);
         S_SCAN:  kn_idx = i_ff + IX_W'(1);
         S_BK0:   kn_idx = bi_idx;
         S_BK1:   kn_idx = bi_idx + k_ff - r_ff;
         default: kn_idx = '0;
      endcase
   end
   assign knot_q = kz_ff ? 32'sd0 : $signed(knot_rd);

   bsdb_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
      .clock   (clock),
      .wr_en   (accept && req_tuser == KIND_KNOT && int'(in_slot) < KNOT_DEPTH),
      .wr_addr (KA_W'(in_slot)),
      .wr_data (in_knot),
      .rd_addr (KA_W'(kn_idx)),
      .rd_data (knot_rd));

   // control point memory
   logic [127:0] point_rd;
   bsdb_ram #(.WIDTH(128), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (accept && req_tuser == KIND_POINT && int'(in_slot) < MAX_POINTS),
      .wr_addr (PT_W'(in_slot)),
      .wr_data (in_point),
      .rd_addr (PT_W'(base + j_ff)),
      .rd_data (point_rd));

   // blend rows, one row read per cycle
   logic [IX_W-1:0] bl_raddr;
   logic [127:0]    blend_rd;
   always_comb begin
      unique case (state_ff)
         S_RA:    bl_raddr = j_ff + IX_W'(1);
         S_FIN:   bl_raddr = '0;
         default: bl_raddr = j_ff;
      endcase
   end

   bsdb_ram #(.WIDTH(128), .DEPTH(MAX_ORDER)) u_blend_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_CP1 || state_ff == S_WB),
      .wr_addr (j_ff[RW_W-1:0]),
      .wr_data ((state_ff == S_CP1) ? point_rd : rowa_ff),
      .rd_addr (bl_raddr[RW_W-1:0]),
      .rd_data (blend_rd));

   // blend factor numerator and denominator
   logic signed [32:0] den_s, num_s;
   logic [32:0]        den_mag, num_mag;
   assign den_s   = 33'(knot_q) - 33'(ui_ff);
   assign num_s   = 33'(t_ff) - 33'(ui_ff);
   assign den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);
   assign num_mag = num_s[32] ? 33'(-num_s) : 33'(num_s);

   div_req_type div_req;
   div_rsp_type div_rsp;
   assign div_req.start    = state_ff == S_BK2 && den_s != 33'sd0;
   assign div_req.dividend = {num_mag, 16'd0};
   assign div_req.divisor  = den_mag;

   bsdb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp));

   // truncated quotient saturated to q16.16
   logic [31:0] f_sat;
   always_comb begin
      if (!fneg_ff) begin
         f_sat = (div_rsp.quotient > DIV_N_W'(32'h7fffffff)) ? 32'h7fffffff
                                                             : div_rsp.quotient[31:0];
      end else begin
         f_sat = (div_rsp.quotient > DIV_N_W'(33'h080000000)) ? 32'h80000000
                                                              : 32'(-div_rsp.quotient[31:0]);
      end
   end

   // one coordinate lane of the blend
   logic signed [31:0] lane_a, lane_b, lane_new;
   logic signed [32:0] lane_d;
   logic signed [65:0] prod_rnd;
   logic signed [50:0] lane_sum;
   assign lane_a   = rowa_ff[c_ff*32 +: 32];
   assign lane_b   = rowb_ff[c_ff*32 +: 32];
   assign lane_d   = 33'(lane_b) - 33'(lane_a);
   assign prod_rnd = 66'(prod_ff) + 66'sd32768;
   assign lane_sum = 51'($signed(prod_rnd[65:16])) + 51'(lane_a);
   always_comb begin
      if (lane_sum > 51'sd2147483647) begin
         lane_new = 32'sh7fffffff;
      end else if (lane_sum < -51'sd2147483648) begin
         lane_new = 32'sh80000000;
      end else begin
         lane_new = lane_sum[31:0];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= ORDER_RST;
         last_ff      <= LAST_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         kz_ff <= int'(kn_idx) >= KNOT_DEPTH;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ORDER: order_ff <= csr_data[3:0];
               CSR_LAST:  last_ff  <= csr_data[5:0];
            endcase
         end
         // output register: loaded on hand-over, freed when taken
         if (state_ff == S_EMIT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_tuser == KIND_EVAL) begin
                  k_ff <= k_cl;
                  n_ff <= n_cl;
                  t_ff <= in_t;
                  l_ff <= '0;
                  if (n_cl + IX_W'(1) < k_cl) begin
                     st_ff    <= ST_DOMAIN;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_LO;
                  end
               end
            end
            S_LO: begin
               ui_ff    <= knot_q;
               state_ff <= S_HI;
            end
            S_HI: begin
               i_ff  <= k_ff - IX_W'(1);
               j_ff  <= '0;
               if (t_ff < ui_ff || t_ff > knot_q) begin
                  st_ff    <= ST_DOMAIN;
                  state_ff <= S_EMIT;
               end else if (t_ff == knot_q) begin
                  l_ff     <= n_ff;
                  state_ff <= S_CP0;
               end else begin
                  l_ff     <= k_ff - IX_W'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (knot_q <= t_ff) begin
                  l_ff <= i_ff;
               end
               if (i_ff == n_ff) begin
                  state_ff <= S_CP0;
               end else begin
                  i_ff <= i_ff + IX_W'(1);
               end
            end
            S_CP0: state_ff <= S_CP1;
            S_CP1: begin
               if (j_ff == k_ff - IX_W'(1)) begin
                  j_ff <= '0;
                  r_ff <= IX_W'(1);
                  state_ff <= (k_ff == IX_W'(1)) ? S_FIN : S_BK0;
               end else begin
                  j_ff     <= j_ff + IX_W'(1);
                  state_ff <= S_CP0;
               end
            end
            S_BK0: state_ff <= S_BK1;
            S_BK1: begin
               ui_ff    <= knot_q;
               state_ff <= S_BK2;
            end
            S_BK2: begin
               fneg_ff <= num_s[32] ^ den_s[32];
               if (den_s == 33'sd0) begin
                  st_ff    <= ST_ZERO_IV;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  f_ff     <= f_sat;
                  state_ff <= S_RA;
               end
            end
            S_RA: begin
               rowa_ff  <= blend_rd;
               state_ff <= S_RB;
            end
            S_RB: begin
               rowb_ff  <= blend_rd;
               c_ff     <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= 65'(f_ff) * 65'(lane_d);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               rowa_ff[c_ff*32 +: 32] <= lane_new;
               c_ff <= c_ff + 2'd1;
               state_ff <= (c_ff == 2'd3) ? S_WB : S_MUL;
            end
            S_WB: begin
               if (j_ff == k_ff - IX_W'(1) - r_ff) begin
                  j_ff <= '0;
                  if (r_ff == k_ff - IX_W'(1)) begin
                     state_ff <= S_FIN;
                  end else begin
                     r_ff     <= r_ff + IX_W'(1);
                     state_ff <= S_BK0;
                  end
               end else begin
                  j_ff     <= j_ff + IX_W'(1);
                  state_ff <= S_BK0;
               end
            end
            S_FIN: state_ff <= S_FIN2;
            S_FIN2: begin
               rowa_ff  <= blend_rd;
               st_ff    <= ST_OK;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_pt_ff    <= (st_ff == ST_OK) ? rowa_ff : 128'd0;
                  rsp_span_ff  <= (st_ff == ST_DOMAIN) ? 7'd0 : l_ff[6:0];
                  rsp_st_ff    <= st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_span_ff, rsp_pt_ff};
   assign rsp_tuser  = rsp_st_ff;

`include "assert_macros.svh"

   `ASSERT_IMP(a_busy_holds_req, state_ff != S_IDLE, !req_tready)
   `ASSERT_IMP(a_status_legal, rsp_valid_ff, rsp_st_ff == ST_OK || rsp_st_ff == ST_DOMAIN || rsp_st_ff == ST_ZERO_IV)
   `ASSERT_IMP(a_domain_no_span, rsp_valid_ff && rsp_st_ff == ST_DOMAIN, rsp_span_ff == 7'd0)
   `ASSERT_NXT(a_div_done_in_div, div_rsp.done, state_ff == S_RA)

endmodule
